FILE: src/hltp_pkg.sv
package hltp_pkg;

    // Field widths fixed by the stream format
    localparam int CODE_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int CFG_W    = 11;
    localparam int IDX_W    = 10;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    // Result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_LIMIT = 2'd2
    } status_t;

    // Two djb2 rounds from 5381 collapse to 5381*33*33 + 33*a + b, which stays below 2^24
    localparam int HASH_W = 24;
    localparam logic [HASH_W-1:0] HASH_BASE = 24'd5859909;

    // Remainder unit: four quotient bits per cycle
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = HASH_W / MOD_BITS;
    localparam int MOD_CNT_W = 3;

    // Saturation point of the worst probe count
    localparam logic [IDX_W-1:0] PROBE_SAT = 10'h3FF;

    typedef struct packed {
        logic clear;
        logic accept;
        logic load;
        logic lookup;
        logic mark_full;
        logic mark_limit;
        logic mark_ok;
        logic advance;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic full;
        logic over_limit;
        logic slot_free;
        logic out_free;
    } sts_t;

endpackage

FILE: src/hltp_rem.sv
module hltp_rem #(
    parameter int DW = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hltp_pkg::HASH_W-1:0]   dividend,
    input  logic [DW-1:0]                 divisor,
    output logic                          done,
    output logic [DW-1:0]                 rem
);

    logic [hltp_pkg::HASH_W-1:0]    shift_reg, shift_next;
    logic [DW-1:0]                  rem_reg, rem_next;
    logic [hltp_pkg::MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [DW-1:0]                  step_rem;

    // Restoring remainder, MOD_BITS bits from the top each cycle
    always_comb
    begin
        logic [DW:0] part;
        step_rem = rem_reg;
        for (int i = 0; i < hltp_pkg::MOD_BITS; i++)
        begin
            part = {step_rem, shift_reg[hltp_pkg::HASH_W-1-i]};
            if (part >= {1'b0, divisor})
            begin
                part = part - {1'b0, divisor};
            end
            step_rem = DW'(part);
        end
    end

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        if (start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
            done_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            shift_next = shift_reg << hltp_pkg::MOD_BITS;
            rem_next   = step_rem;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == hltp_pkg::MOD_CNT_W'(hltp_pkg::MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: src/hltp_ctrl.sv
module hltp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  hltp_pkg::sts_t  sts,
    output hltp_pkg::cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_HASH   = 6'b000100,
        S_LOOKUP = 6'b001000,
        S_PROBE  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (sts.mod_done)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (sts.full)
                begin
                    cmd.mark_full = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                priority if (sts.over_limit)
                begin
                    cmd.mark_limit = 1'b1;
                    state_next     = S_FINISH;
                end
                else if (sts.slot_free)
                begin
                    cmd.mark_ok = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/hltp_dp.sv
module hltp_dp #(
    parameter int TABLE_SLOTS = 1024,
    parameter int PROBE_LIMIT = 1000
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hltp_pkg::cmd_t                  cmd,
    output hltp_pkg::sts_t                  sts,
    input  logic                            cfg_we,
    input  logic [hltp_pkg::CFG_W-1:0]      cfg_data,
    input  logic [hltp_pkg::CODE_W-1:0]     code_first,
    input  logic [hltp_pkg::CODE_W-1:0]     code_second,
    input  logic [hltp_pkg::VALUE_W-1:0]    pair_value,
    input  logic                            out_ready,
    output logic                            out_valid,
    output hltp_pkg::status_t               status,
    output logic [hltp_pkg::IDX_W-1:0]      slot_index,
    output logic [hltp_pkg::IDX_W-1:0]      entry_index,
    output logic [hltp_pkg::IDX_W-1:0]      probe_count,
    output logic [hltp_pkg::IDX_W-1:0]      worst_probes,
    output logic [hltp_pkg::COUNT_W-1:0]    filled_count
);

    localparam int SW  = $clog2(TABLE_SLOTS);
    localparam int CUW = $clog2(TABLE_SLOTS + 1);
    localparam int TW  = $clog2(PROBE_LIMIT + 2);

    // Table storage
    logic                               occ_mem   [TABLE_SLOTS];
    logic [2*hltp_pkg::CODE_W-1:0]      pair_mem  [TABLE_SLOTS];
    logic [hltp_pkg::IDX_W-1:0]         entry_mem [TABLE_SLOTS];
    logic [hltp_pkg::VALUE_W-1:0]       value_mem [TABLE_SLOTS];

    logic [CUW-1:0]                     cap_reg, cap_next;
    logic [CUW-1:0]                     total_reg, total_next;
    logic [hltp_pkg::IDX_W-1:0]         max_reg, max_next;
    logic [SW-1:0]                      clr_cnt_reg, clr_cnt_next;
    logic [SW-1:0]                      slot_reg, slot_next;
    logic [TW-1:0]                      tries_reg, tries_next;
    hltp_pkg::status_t                  res_reg, res_next;
    logic [2*hltp_pkg::CODE_W-1:0]      pair_reg;
    logic [hltp_pkg::VALUE_W-1:0]       value_reg;
    logic                               occ_q;

    logic                               out_valid_reg, out_valid_next;
    hltp_pkg::status_t                  o_status_reg;
    logic [hltp_pkg::IDX_W-1:0]         o_slot_reg, o_entry_reg, o_probe_reg, o_worst_reg;
    logic [hltp_pkg::COUNT_W-1:0]       o_filled_reg;

    logic [hltp_pkg::HASH_W-1:0]        hash;
    logic [CUW-1:0]                     rem;
    logic                               mod_done;
    logic [CUW-1:0]                     slot_inc;
    logic [SW-1:0]                      slot_wrap;
    logic [SW-1:0]                      rd_addr;
    logic [SW-1:0]                      wr_addr;
    logic                               wr_en;
    logic                               ins_ok;

    // h = 5381*33*33 + 33*a + b
    assign hash = hltp_pkg::HASH_BASE
                + {11'd0, code_first, 5'd0}
                + {16'd0, code_first}
                + {16'd0, code_second};

    hltp_rem #(
        .DW (CUW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.accept),
        .dividend (hash),
        .divisor  (cap_reg),
        .done     (mod_done),
        .rem      (rem)
    );

    assign slot_inc  = CUW'(slot_reg) + CUW'(1);
    assign slot_wrap = (slot_inc == cap_reg) ? '0 : SW'(slot_inc);
    assign rd_addr   = cmd.lookup ? slot_reg : slot_wrap;
    assign ins_ok    = cmd.commit && (res_reg == hltp_pkg::ST_OK);
    assign wr_en     = cmd.clear || ins_ok;
    assign wr_addr   = cmd.clear ? clr_cnt_reg : slot_reg;

    assign sts.clr_last   = (clr_cnt_reg == SW'(TABLE_SLOTS - 1));
    assign sts.mod_done   = mod_done;
    assign sts.full       = (total_reg >= cap_reg);
    assign sts.over_limit = (tries_reg > TW'(PROBE_LIMIT));
    assign sts.slot_free  = !occ_q;
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        cap_next       = cap_reg;
        total_next     = total_reg;
        max_next       = max_reg;
        clr_cnt_next   = clr_cnt_reg;
        slot_next      = slot_reg;
        tries_next     = tries_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;

        // Clamp the capacity on write: zero acts as one, oversize as full size
        if (cfg_we)
        begin
            if (cfg_data == '0)
            begin
                cap_next = CUW'(1);
            end
            else if (32'(cfg_data) > 32'(TABLE_SLOTS))
            begin
                cap_next = CUW'(TABLE_SLOTS);
            end
            else
            begin
                cap_next = CUW'(cfg_data);
            end
        end

        if (cmd.clear)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if (cmd.load)
        begin
            slot_next  = SW'(rem);
            tries_next = '0;
        end
        if (cmd.advance)
        begin
            slot_next  = slot_wrap;
            tries_next = tries_reg + 1'b1;
        end
        if (cmd.mark_full)
        begin
            res_next = hltp_pkg::ST_FULL;
        end
        if (cmd.mark_limit)
        begin
            res_next = hltp_pkg::ST_LIMIT;
        end
        if (cmd.mark_ok)
        begin
            res_next = hltp_pkg::ST_OK;
        end

        if (cmd.commit)
        begin
            if (32'(tries_reg) > 32'(max_reg))
            begin
                max_next = (32'(tries_reg) > 32'(hltp_pkg::PROBE_SAT))
                         ? hltp_pkg::PROBE_SAT : hltp_pkg::IDX_W'(tries_reg);
            end
            if (ins_ok)
            begin
                total_next = total_reg + 1'b1;
            end
        end

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CUW'(TABLE_SLOTS);
            total_reg     <= '0;
            max_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            total_reg     <= total_next;
            max_reg       <= max_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        tries_reg <= tries_next;
        res_reg   <= res_next;
        if (cmd.accept)
        begin
            pair_reg  <= {code_first, code_second};
            value_reg <= pair_value;
        end
        if (cmd.commit)
        begin
            o_status_reg <= res_reg;
            o_slot_reg   <= ins_ok ? hltp_pkg::IDX_W'(slot_reg) : '0;
            o_entry_reg  <= ins_ok ? hltp_pkg::IDX_W'(total_reg) : '0;
            o_probe_reg  <= hltp_pkg::IDX_W'(tries_reg);
            o_worst_reg  <= max_next;
            o_filled_reg <= hltp_pkg::COUNT_W'(total_next);
        end
    end

    // Occupancy memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            occ_mem[wr_addr] <= !cmd.clear;
        end
        occ_q <= occ_mem[rd_addr];
    end

    // Pair, entry number and value stores, written on a successful insert
    always_ff @(posedge clk)
    begin
        if (ins_ok)
        begin
            pair_mem[slot_reg]           <= pair_reg;
            entry_mem[slot_reg]          <= hltp_pkg::IDX_W'(total_reg);
            value_mem[SW'(total_reg)]    <= value_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = o_status_reg;
    assign slot_index   = o_slot_reg;
    assign entry_index  = o_entry_reg;
    assign probe_count  = o_probe_reg;
    assign worst_probes = o_worst_reg;
    assign filled_count = o_filled_reg;

endmodule

FILE: src/hash_table_linear_probe_insert.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  code_first, code_second, pair_value
// m_axis    out        m_axis_tvalid / m_axis_tready  status, slot, entry, probes, worst, filled
// cfg       in         cfg_valid / cfg_ready          table capacity (11 bits)
//
// An item passes from accept to result valid through the hash remainder, the load and read
// of the start slot, the walk over the occupied slots and the load of the result register;
// a table-full item skips the walk. The next item is accepted once the result has loaded.
// After reset the occupancy memory clears one slot a cycle, with no item accepted; write
// the capacity with no item in flight. A waiting result stalls only the final step of the
// next item, not its accept.
module hash_table_linear_probe_insert #(
    parameter int TABLE_SLOTS = 1024,
    parameter int PROBE_LIMIT = 1000
) (
    input  logic        clk,
    input  logic        rst_n,

    // Insert requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // code_first[7:0], code_second[15:8], pair_value[47:16]

    // Insert results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // status[1:0], slot_index[11:2], entry_index[21:12],
                                        // probe_count[31:22], worst_probes[41:32],
                                        // filled_count[52:42], zero[55:53]

    // Capacity register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    hltp_pkg::cmd_t                     cmd;
    hltp_pkg::sts_t                     sts;
    hltp_pkg::status_t                  status;
    logic [hltp_pkg::IDX_W-1:0]         slot_index;
    logic [hltp_pkg::IDX_W-1:0]         entry_index;
    logic [hltp_pkg::IDX_W-1:0]         probe_count;
    logic [hltp_pkg::IDX_W-1:0]         worst_probes;
    logic [hltp_pkg::COUNT_W-1:0]       filled_count;

    // The capacity register accepts a write on any cycle
    assign cfg_ready = 1'b1;

    // Sequence hashing, probing and the final commit
    hltp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hash, occupancy walk, counters, stores and output register
    hltp_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .PROBE_LIMIT (PROBE_LIMIT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_valid),
        .cfg_data     (cfg_data),
        .code_first   (s_axis_tdata[7:0]),
        .code_second  (s_axis_tdata[15:8]),
        .pair_value   (s_axis_tdata[47:16]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .status       (status),
        .slot_index   (slot_index),
        .entry_index  (entry_index),
        .probe_count  (probe_count),
        .worst_probes (worst_probes),
        .filled_count (filled_count)
    );

    // Pack the result fields, lowest field first, pad to whole bytes
    assign m_axis_tdata = {3'b000, filled_count, worst_probes, probe_count,
                           entry_index, slot_index, status};

endmodule
